>>> hw/rtl/stack_insertion_sorter_defines.svh
// Assertion macros for the stack insertion sorter
`ifndef STACK_INSERTION_SORTER_DEFINES_SVH
`define STACK_INSERTION_SORTER_DEFINES_SVH

// same-cycle implication
`define SIS_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define SIS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hw/rtl/sis_pkg.sv
package sis_pkg;

    localparam int CAPACITY = 32;
    localparam int ADDR_W   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W    = ADDR_W + 1;
    localparam int DATA_W   = 32;

    localparam logic [CNT_W-1:0]  CAP_CNT  = CNT_W'(CAPACITY);
    localparam logic [CNT_W-1:0]  ONE_CNT  = CNT_W'(1);
    localparam logic [CNT_W-1:0]  ZERO_CNT = '0;
    localparam logic [ADDR_W-1:0] ONE_ADDR = ADDR_W'(1);
    localparam logic [ADDR_W-1:0] TWO_ADDR = ADDR_W'(2);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_INSERT,
        ST_PLACE,
        ST_EMIT
    } t_state;

endpackage

>>> hw/rtl/stack_insertion_sorter.sv
// Insertion: an item without end of run keeps busy high while it is placed among the
// N entries already stored (one memory read-compare-write per cycle).
// End of run: after the insertion, all stored entries stream out as results, one per cycle,
// each through the registered memory read data. Dropped items (store full) are not stored.
// Synchronous active-low reset clears the entry count, drop flag and control; store
// contents stay undefined. Results cannot be stalled by the receiver.
`include "stack_insertion_sorter_defines.svh"

module stack_insertion_sorter (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               start,
    output logic                               busy,
    input  logic signed [sis_pkg::DATA_W-1:0]  i_item_value,
    input  logic                               i_end_of_run,
    output logic                               o_result_strobe,
    output logic signed [sis_pkg::DATA_W-1:0]  o_sorted_value,
    output logic                               o_final_result,
    output logic                               o_overflowed
);

    sis_pkg::t_state r_state, n_state;

    logic [sis_pkg::DATA_W-1:0] r_mem [sis_pkg::CAPACITY];
    logic [sis_pkg::DATA_W-1:0] r_rdata;

    logic [sis_pkg::CNT_W-1:0]        r_count;
    logic                             r_drop;
    logic [sis_pkg::ADDR_W-1:0]       r_k;
    logic [sis_pkg::ADDR_W-1:0]       r_e;
    logic signed [sis_pkg::DATA_W-1:0] r_v;
    logic                             r_last;
    logic                             r_pend;
    logic                             r_pend_last;
    logic                             r_ovf_out;

    logic                       mem_we;
    logic [sis_pkg::ADDR_W-1:0] mem_waddr;
    logic [sis_pkg::DATA_W-1:0] mem_wdata;
    logic                       mem_re;
    logic [sis_pkg::ADDR_W-1:0] mem_raddr;

    logic                       accept;
    logic                       full;
    logic                       empty;
    logic                       greater;
    logic                       emit_last;
    logic [sis_pkg::CNT_W-1:0]  cnt_m1;

    assign busy      = (r_state != sis_pkg::ST_IDLE);
    assign accept    = start && !busy;
    assign full      = (r_count == sis_pkg::CAP_CNT);
    assign empty     = (r_count == sis_pkg::ZERO_CNT);
    assign greater   = ($signed(r_rdata) > r_v);
    assign cnt_m1    = r_count - sis_pkg::ONE_CNT;
    assign emit_last = ({1'b0, r_e} == cnt_m1);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            sis_pkg::ST_IDLE: begin
                if (accept) begin
                    if (full || empty) begin
                        n_state = i_end_of_run ? sis_pkg::ST_EMIT : sis_pkg::ST_IDLE;
                    end else begin
                        n_state = sis_pkg::ST_INSERT;
                    end
                end
            end
            sis_pkg::ST_INSERT: begin
                if (!greater) begin
                    n_state = r_last ? sis_pkg::ST_EMIT : sis_pkg::ST_IDLE;
                end else if (r_k == sis_pkg::ONE_ADDR) begin
                    n_state = sis_pkg::ST_PLACE;
                end
            end
            sis_pkg::ST_PLACE: begin
                n_state = r_last ? sis_pkg::ST_EMIT : sis_pkg::ST_IDLE;
            end
            sis_pkg::ST_EMIT: begin
                if (emit_last) begin
                    n_state = sis_pkg::ST_IDLE;
                end
            end
            default: n_state = sis_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = '0;
        mem_wdata = i_item_value;
        mem_re    = 1'b0;
        mem_raddr = '0;
        unique case (r_state)
            sis_pkg::ST_IDLE: begin
                if (accept && empty) begin
                    mem_we = 1'b1;
                end else if (accept && !full) begin
                    mem_re    = 1'b1;
                    mem_raddr = cnt_m1[sis_pkg::ADDR_W-1:0];
                end
            end
            sis_pkg::ST_INSERT: begin
                mem_we    = 1'b1;
                mem_waddr = r_k;
                mem_wdata = greater ? r_rdata : r_v;
                if (greater && r_k != sis_pkg::ONE_ADDR) begin
                    mem_re    = 1'b1;
                    mem_raddr = r_k - sis_pkg::TWO_ADDR;
                end
            end
            sis_pkg::ST_PLACE: begin
                mem_we    = 1'b1;
                mem_wdata = r_v;
            end
            sis_pkg::ST_EMIT: begin
                mem_re    = 1'b1;
                mem_raddr = r_e;
            end
            default: begin
                mem_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            r_rdata <= r_mem[mem_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= sis_pkg::ST_IDLE;
            r_count     <= '0;
            r_drop      <= 1'b0;
            r_e         <= '0;
            r_pend      <= 1'b0;
            r_pend_last <= 1'b0;
            r_last      <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_pend      <= 1'b0;
            r_pend_last <= 1'b0;
            case (r_state)
                sis_pkg::ST_IDLE: begin
                    r_e <= '0;
                    if (accept) begin
                        r_last <= i_end_of_run;
                        if (full) begin
                            r_drop <= 1'b1;
                        end else if (empty) begin
                            r_count <= sis_pkg::ONE_CNT;
                        end
                    end
                end
                sis_pkg::ST_INSERT: begin
                    if (!greater) begin
                        r_count <= r_count + sis_pkg::ONE_CNT;
                    end
                end
                sis_pkg::ST_PLACE: begin
                    r_count <= r_count + sis_pkg::ONE_CNT;
                end
                sis_pkg::ST_EMIT: begin
                    r_pend      <= 1'b1;
                    r_pend_last <= emit_last;
                    r_e         <= r_e + sis_pkg::ONE_ADDR;
                    if (emit_last) begin
                        r_count <= '0;
                        r_drop  <= 1'b0;
                        r_e     <= '0;
                    end
                end
                default: begin
                    r_e <= '0;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_v <= i_item_value;
            r_k <= r_count[sis_pkg::ADDR_W-1:0];
        end else if (r_state == sis_pkg::ST_INSERT && greater) begin
            r_k <= r_k - sis_pkg::ONE_ADDR;
        end
        if (r_state == sis_pkg::ST_EMIT) begin
            r_ovf_out <= r_drop;
        end
    end

    assign o_result_strobe = r_pend;
    assign o_sorted_value  = $signed(r_rdata);
    assign o_final_result  = r_pend_last;
    assign o_overflowed    = r_ovf_out;

    `SIS_ASSERT_NOW(a_count_bound, i_clk, i_rst_n, 1'b1, r_count <= sis_pkg::CAP_CNT, "count beyond capacity")
    `SIS_ASSERT_NEXT(a_emit_strobe, i_clk, i_rst_n, r_state == sis_pkg::ST_EMIT, o_result_strobe, "emit read without result")
    `SIS_ASSERT_NOW(a_final_empty, i_clk, i_rst_n, o_final_result, o_result_strobe && r_count == sis_pkg::ZERO_CNT, "store not emptied at final result")
    `SIS_ASSERT_NEXT(a_drop_flag, i_clk, i_rst_n, accept && full && !i_end_of_run, r_drop, "drop not recorded")

endmodule
